### rtl/weekly_dispense_schedule_table_macros.svh
// Assertion macros for the weekly dispense schedule table checker.
`ifndef WEEKLY_DISPENSE_SCHEDULE_TABLE_MACROS_SVH
`define WEEKLY_DISPENSE_SCHEDULE_TABLE_MACROS_SVH

// Check a property on every edge outside reset.
`define WDST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define WDST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/wdst_pkg.sv
// Shared types and constants of the weekly dispense schedule table.
`timescale 1ns / 1ps
`default_nettype none
package wdst_pkg;

  localparam int DEF_SLOTS_PER_DAY = 16;
  localparam int DAYS_PER_WEEK     = 7;
  localparam int MIN_PER_HOUR      = 60;

  localparam int ACTION_W      = 2;
  localparam int HOUR_W        = 5;
  localparam int MINUTE_W      = 6;
  localparam int DAY_W         = 3;
  localparam int AMOUNT_W      = 16;
  localparam int TIME_W        = 11;
  localparam int FIRE_SLOT_W   = 4;

  localparam logic [DAY_W-1:0] ALL_DAYS = 3'd7;
  localparam logic [DAY_W-1:0] LAST_DAY = 3'(DAYS_PER_WEEK - 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_CHECK   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_NEW_DAY = 2'd2,
    ACT_ERASE   = 2'd3
  } wdst_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } wdst_state_t;

  // Control of the slot store: read, write and clear all.
  typedef struct packed {
    logic re;
    logic we;
    logic clr_all;
  } wdst_store_ctl_t;

endpackage
`default_nettype wire

### rtl/wdst_slot_store.sv
// Slot store: time and amount memory with per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module wdst_slot_store #(
  parameter int DEPTH  = wdst_pkg::DAYS_PER_WEEK * wdst_pkg::DEF_SLOTS_PER_DAY,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wdst_pkg::wdst_store_ctl_t      ctl,
  input  logic [ADDR_W-1:0]              addr,
  input  logic [wdst_pkg::TIME_W-1:0]    wr_time,
  input  logic [wdst_pkg::AMOUNT_W-1:0]  wr_amount,
  output logic [wdst_pkg::TIME_W-1:0]    rd_time,
  output logic [wdst_pkg::AMOUNT_W-1:0]  rd_amount
);
  import wdst_pkg::*;

  logic [TIME_W-1:0]   mem_time [DEPTH];
  logic [AMOUNT_W-1:0] mem_amount [DEPTH];
  logic [DEPTH-1:0]    valid_r;
  logic [TIME_W-1:0]   rd_time_r;
  logic [AMOUNT_W-1:0] rd_amount_r;
  logic                rd_valid_r;

  // Valid bits: an entry never written since erase reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      valid_r <= '0;
    end else if (ctl.we) begin
      valid_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_time[addr]   <= wr_time;
      mem_amount[addr] <= wr_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rd_time_r   <= mem_time[addr];
      rd_amount_r <= mem_amount[addr];
      rd_valid_r  <= valid_r[addr];
    end
  end

  assign rd_time   = rd_valid_r ? rd_time_r : '0;
  assign rd_amount = rd_valid_r ? rd_amount_r : '0;

endmodule
`default_nettype wire

### rtl/weekly_dispense_schedule_table.sv
// Top level of the weekly dispense schedule table: command decode and slot sequencer.
// Erase, and check or new day for day 7, strobe the result in the cycle after start.
// Check, new day and single-day add walk the slots of one row, a READ and an EVAL state per slot.
// Add for all days walks the rows in turn, from day 0 to day 6, before the strobe.
// busy stays high for the walk; the single-port slot memory read sets the READ and EVAL step.
// Reset: done flags set, table empty at once by valid bits; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module weekly_dispense_schedule_table #(
  parameter int SLOTS_PER_DAY = wdst_pkg::DEF_SLOTS_PER_DAY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [wdst_pkg::ACTION_W-1:0]      in_action,
  input  logic [wdst_pkg::HOUR_W-1:0]        in_hour,
  input  logic [wdst_pkg::MINUTE_W-1:0]      in_minute,
  input  logic [wdst_pkg::DAY_W-1:0]         in_day,
  input  logic [wdst_pkg::AMOUNT_W-1:0]      in_amount,
  output logic                               out_valid,
  output logic                               out_fire,
  output logic [wdst_pkg::AMOUNT_W-1:0]      out_fire_amount,
  output logic [wdst_pkg::FIRE_SLOT_W-1:0]   out_fire_slot,
  output logic                               out_no_room
);
  import wdst_pkg::*;

  localparam int DEPTH  = DAYS_PER_WEEK * SLOTS_PER_DAY;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_DAY - 1);

  // Sequencer state
  wdst_state_t          state_r, state_nxt;
  wdst_action_t         act_r, act_nxt;
  logic [DAY_W-1:0]     day_r, day_nxt;
  logic                 all_days_r, all_days_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [AMOUNT_W-1:0]  amt_r, amt_nxt;
  logic                 room_miss_r, room_miss_nxt;
  logic [SLOTS_PER_DAY-1:0] done_r, done_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_fire_r, out_fire_nxt;
  logic [AMOUNT_W-1:0]  out_amt_r, out_amt_nxt;
  logic [FIRE_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic                 out_no_room_r, out_no_room_nxt;

  // Slot store interface
  wdst_store_ctl_t      st_ctl;
  logic [ADDR_W-1:0]    st_addr;
  logic [TIME_W-1:0]    rd_time;
  logic [AMOUNT_W-1:0]  rd_amount;

  logic                 accept;
  logic [TIME_W-1:0]    in_now;
  logic                 slot_empty;
  logic                 last_slot;

  assign accept     = start && (state_r == ST_IDLE);
  // Time of day in minutes, kept to 11 bits
  assign in_now     = TIME_W'(int'(in_hour) * MIN_PER_HOUR + int'(in_minute));
  assign st_addr    = ADDR_W'(int'(day_r) * SLOTS_PER_DAY + int'(slot_r));
  assign slot_empty = (rd_time == '0);
  assign last_slot  = (slot_r == LAST_SLOT);

  wdst_slot_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (st_ctl),
    .addr      (st_addr),
    .wr_time   (now_r),
    .wr_amount (amt_r),
    .rd_time   (rd_time),
    .rd_amount (rd_amount)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      done_r        <= '1;
      out_valid_r   <= 1'b0;
      act_r         <= ACT_CHECK;
      day_r         <= '0;
      all_days_r    <= 1'b0;
      slot_r        <= '0;
      room_miss_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      done_r        <= done_nxt;
      out_valid_r   <= out_valid_nxt;
      act_r         <= act_nxt;
      day_r         <= day_nxt;
      all_days_r    <= all_days_nxt;
      slot_r        <= slot_nxt;
      room_miss_r   <= room_miss_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    now_r         <= now_nxt;
    amt_r         <= amt_nxt;
    out_fire_r    <= out_fire_nxt;
    out_amt_r     <= out_amt_nxt;
    out_slot_r    <= out_slot_nxt;
    out_no_room_r <= out_no_room_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    day_nxt         = day_r;
    all_days_nxt    = all_days_r;
    slot_nxt        = slot_r;
    now_nxt         = now_r;
    amt_nxt         = amt_r;
    room_miss_nxt   = room_miss_r;
    done_nxt        = done_r;
    out_valid_nxt   = 1'b0;
    out_fire_nxt    = out_fire_r;
    out_amt_nxt     = out_amt_r;
    out_slot_nxt    = out_slot_r;
    out_no_room_nxt = out_no_room_r;
    st_ctl          = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt         = wdst_action_t'(in_action);
          now_nxt         = in_now;
          amt_nxt         = in_amount;
          slot_nxt        = '0;
          room_miss_nxt   = 1'b0;
          all_days_nxt    = (in_day == ALL_DAYS);
          day_nxt         = (in_day == ALL_DAYS) ? '0 : in_day;
          out_fire_nxt    = 1'b0;
          out_amt_nxt     = '0;
          out_slot_nxt    = '0;
          out_no_room_nxt = 1'b0;
          if (wdst_action_t'(in_action) == ACT_ERASE) begin
            // Empty the table and set every done flag in one step
            st_ctl.clr_all = 1'b1;
            done_nxt       = '1;
            out_valid_nxt  = 1'b1;
          end else if ((in_day == ALL_DAYS) &&
                       (wdst_action_t'(in_action) != ACT_ADD)) begin
            // Check or new day for no weekday: report nothing, keep state
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end

      ST_READ: begin
        // Fetch the slot at day_r, slot_r
        st_ctl.re = 1'b1;
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        state_nxt = ST_READ;
        slot_nxt  = slot_r + SLOT_W'(1);
        case (act_r)
          ACT_CHECK: begin
            if (!done_r[slot_r] && (rd_time <= now_r)) begin
              // Fire the first due slot and mark it done
              done_nxt[slot_r] = 1'b1;
              out_fire_nxt     = 1'b1;
              out_amt_nxt      = rd_amount;
              out_slot_nxt     = FIRE_SLOT_W'(slot_r);
              out_valid_nxt    = 1'b1;
              state_nxt        = ST_IDLE;
            end else if (last_slot) begin
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          ACT_ADD: begin
            if (slot_empty || last_slot) begin
              if (slot_empty) begin
                st_ctl.we        = 1'b1;
                done_nxt[slot_r] = 1'b0;
              end
              // Row finished: advance to the next day or report
              if (all_days_r && (day_r != LAST_DAY)) begin
                room_miss_nxt = room_miss_r | !slot_empty;
                day_nxt       = day_r + DAY_W'(1);
                slot_nxt      = '0;
              end else begin
                out_no_room_nxt = room_miss_r | !slot_empty;
                out_valid_nxt   = 1'b1;
                state_nxt       = ST_IDLE;
              end
            end
          end
          ACT_NEW_DAY: begin
            done_nxt[slot_r] = slot_empty;
            if (last_slot) begin
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_fire        = out_fire_r;
  assign out_fire_amount = out_amt_r;
  assign out_fire_slot   = out_slot_r;
  assign out_no_room     = out_no_room_r;

endmodule
`default_nettype wire

### rtl/wdst_checker.sv
// Port-level checker for the weekly dispense schedule table, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "weekly_dispense_schedule_table_macros.svh"
module wdst_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [wdst_pkg::ACTION_W-1:0]      in_action,
  input logic                               out_valid,
  input logic                               out_fire,
  input logic [wdst_pkg::AMOUNT_W-1:0]      out_fire_amount,
  input logic [wdst_pkg::FIRE_SLOT_W-1:0]   out_fire_slot,
  input logic                               out_no_room
);
  import wdst_pkg::*;

  `WDST_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy && !out_valid, "not idle after reset")
  `WDST_ASSERT(a_quiet_fields, clk, rst_n, out_valid && !out_fire |-> out_fire_amount == '0 && out_fire_slot == '0, "fire fields set without fire")
  `WDST_ASSERT(a_fire_xor_room, clk, rst_n, out_valid |-> !(out_fire && out_no_room), "fire and no_room together")
  `WDST_ASSERT(a_erase_quick, clk, rst_n, start && !busy && in_action == ACT_ERASE |=> out_valid && !out_fire && !out_no_room && !busy, "erase result missing")
  `WDST_ASSERT(a_add_walks, clk, rst_n, start && !busy && in_action == ACT_ADD |=> busy && !out_valid, "add did not start a walk")

endmodule

bind weekly_dispense_schedule_table wdst_checker u_wdst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_fire        (out_fire),
  .out_fire_amount (out_fire_amount),
  .out_fire_slot   (out_fire_slot),
  .out_no_room     (out_no_room)
);
`default_nettype wire

### tb/tb_weekly_dispense_schedule_table.sv
// Self-checking testbench for the weekly dispense schedule table: directed and random commands.
`timescale 1ns / 1ps
`default_nettype none
module tb_weekly_dispense_schedule_table;
  import wdst_pkg::*;

  localparam int SLOTS        = DEF_SLOTS_PER_DAY;
  // Worst walk is an add for all days, which walks every row.
  localparam int TAIL_CYCLES  = 16 * SLOTS + 64;
  localparam int ITEMS_TARGET = 650;
  localparam int MAX_IDLE     = 12;
  // Watchdog limit on the whole run, in ns.
  localparam int RUN_LIMIT_NS = 8_000_000;
  localparam int LAST_MINUTE  = 31 * MIN_PER_HOUR + 63;

  // One command transaction plus the idle cycles the driver spends before it.
  typedef struct {
    wdst_action_t          act;
    logic [HOUR_W-1:0]     hour;
    logic [MINUTE_W-1:0]   minute;
    logic [DAY_W-1:0]      day;
    logic [AMOUNT_W-1:0]   amount;
    int unsigned           gap;
    bit                    drain_first;
  } sched_cmd_t;

  typedef struct packed {
    logic                   fire;
    logic [AMOUNT_W-1:0]    amount;
    logic [FIRE_SLOT_W-1:0] slot;
    logic                   no_room;
  } dispense_res_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   start     = 1'b0;
  logic [ACTION_W-1:0]    in_action = '0;
  logic [HOUR_W-1:0]      in_hour   = '0;
  logic [MINUTE_W-1:0]    in_minute = '0;
  logic [DAY_W-1:0]       in_day    = '0;
  logic [AMOUNT_W-1:0]    in_amount = '0;

  logic                   busy;
  logic                   out_valid;
  logic                   out_fire;
  logic [AMOUNT_W-1:0]    out_fire_amount;
  logic [FIRE_SLOT_W-1:0] out_fire_slot;
  logic                   out_no_room;

  weekly_dispense_schedule_table #(
    .SLOTS_PER_DAY(SLOTS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_hour        (in_hour),
    .in_minute      (in_minute),
    .in_day         (in_day),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_fire       (out_fire),
    .out_fire_amount(out_fire_amount),
    .out_fire_slot  (out_fire_slot),
    .out_no_room    (out_no_room)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Behavioral copy of the schedule table. The done flags are shared by all
  // days, so a flag cleared by an add on one day lets the same slot index
  // fire on every other day once due; an empty slot there is due at once.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]   sched_time [DAYS_PER_WEEK][SLOTS];
  logic [AMOUNT_W-1:0] sched_amt  [DAYS_PER_WEEK][SLOTS];
  logic [SLOTS-1:0]    slot_done_flags;

  function automatic void clear_schedule();
    for (int d = 0; d < DAYS_PER_WEEK; d++) begin
      for (int s = 0; s < SLOTS; s++) begin
        sched_time[d][s] = '0;
        sched_amt[d][s]  = '0;
      end
    end
    slot_done_flags = '1;
  endfunction

  // Fill the first empty slot of one row; report whether the row had room.
  // A time of zero is stored as given and the slot still counts as empty.
  function automatic bit place_in_row(int d, logic [TIME_W-1:0] t, logic [AMOUNT_W-1:0] a);
    for (int s = 0; s < SLOTS; s++) begin
      if (sched_time[d][s] == '0) begin
        sched_time[d][s]   = t;
        sched_amt[d][s]    = a;
        slot_done_flags[s] = 1'b0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the table by one command and return the result it strobes.
  function automatic dispense_res_t apply_schedule_cmd(wdst_action_t act,
                                                       logic [HOUR_W-1:0] hour,
                                                       logic [MINUTE_W-1:0] minute,
                                                       logic [DAY_W-1:0] day,
                                                       logic [AMOUNT_W-1:0] amount);
    dispense_res_t     r;
    logic [TIME_W-1:0] now;
    r   = '0;
    now = TIME_W'(hour * MIN_PER_HOUR + minute);
    case (act)
      ACT_CHECK: begin
        // Day seven never fires and leaves the flags alone.
        if (day <= LAST_DAY) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!slot_done_flags[s] && sched_time[day][s] <= now) begin
              r.fire             = 1'b1;
              r.amount           = sched_amt[day][s];
              r.slot             = FIRE_SLOT_W'(s);
              slot_done_flags[s] = 1'b1;
              break;
            end
          end
        end
      end
      ACT_ADD: begin
        if (day == ALL_DAYS) begin
          // Every row takes its own first empty slot; any full row flags no room.
          for (int d = 0; d < DAYS_PER_WEEK; d++) begin
            if (!place_in_row(d, now, amount)) r.no_room = 1'b1;
          end
        end else if (!place_in_row(day, now, amount)) begin
          r.no_room = 1'b1;
        end
      end
      ACT_NEW_DAY: begin
        if (day <= LAST_DAY) begin
          for (int s = 0; s < SLOTS; s++) slot_done_flags[s] = (sched_time[day][s] == '0);
        end
      end
      ACT_ERASE: begin
        clear_schedule();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store. The driver pops one command at a time; gap and drain
  // request travel with each command.
  // ---------------------------------------------------------------------------
  sched_cmd_t    pending_cmds_q[$];
  dispense_res_t owed_results_q[$];
  int            results_owed = 0;
  int            err_cnt      = 0;

  bit gap_burst  = 1'b0;
  bit drain_next = 1'b0;

  task automatic queue_cmd(input wdst_action_t act, input int hour, input int minute,
                           input int day, input int amount);
    sched_cmd_t c;
    c.act         = act;
    c.hour        = HOUR_W'(hour);
    c.minute      = MINUTE_W'(minute);
    c.day         = DAY_W'(day);
    c.amount      = AMOUNT_W'(amount);
    c.gap         = gap_burst ? 0 : $urandom_range(0, MAX_IDLE);
    c.drain_first = drain_next;
    drain_next    = 1'b0;
    pending_cmds_q.push_back(c);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold start and the fields until busy is low at an edge, then move
  // on. A command marked for drain waits until every owed result is back.
  // ---------------------------------------------------------------------------
  sched_cmd_t  next_cmd;
  bit          holding_cmd    = 1'b0;
  bit          awaiting_drain = 1'b0;
  int unsigned idle_left      = 0;

  always @(posedge clk) begin : driver
    bit go;
    go = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (!holding_cmd && pending_cmds_q.size() != 0) begin
        next_cmd       = pending_cmds_q.pop_front();
        holding_cmd    = 1'b1;
        idle_left      = next_cmd.gap;
        awaiting_drain = next_cmd.drain_first;
      end
      if (holding_cmd) begin
        if (awaiting_drain) begin
          // Only trust the owed count once start has been low for an edge.
          if (!start && !busy && results_owed == 0) awaiting_drain = 1'b0;
        end else if (idle_left != 0) begin
          idle_left--;
        end else begin
          go = 1'b1;
        end
      end
      if (go) begin
        start       <= 1'b1;
        in_action   <= next_cmd.act;
        in_hour     <= next_cmd.hour;
        in_minute   <= next_cmd.minute;
        in_day      <= next_cmd.day;
        in_amount   <= next_cmd.amount;
        holding_cmd  = 1'b0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the strobed result against the oldest owed one first, then
  // predict for a transaction accepted at this same edge. The earliest strobe
  // comes in the cycle after acceptance, so the order cannot mix them up.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [AMOUNT_W-1:0] want,
                             input logic [AMOUNT_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    dispense_res_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (owed_results_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with none owed, expected nothing, actual fire=%0b amt=%0h",
                   $time, out_fire, out_fire_amount);
        end else begin
          want = owed_results_q.pop_front();
          check_field("fire", AMOUNT_W'(want.fire), AMOUNT_W'(out_fire));
          check_field("fire_amount", want.amount, out_fire_amount);
          check_field("fire_slot", AMOUNT_W'(want.slot), AMOUNT_W'(out_fire_slot));
          check_field("no_room", AMOUNT_W'(want.no_room), AMOUNT_W'(out_no_room));
        end
      end
      if (start && !busy) begin
        owed_results_q.push_back(apply_schedule_cmd(wdst_action_t'(in_action), in_hour,
                                                    in_minute, in_day, in_amount));
      end
      results_owed <= owed_results_q.size();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int hour;
    int minute;
    int today;
    int tnow;
    int day;
    clear_schedule();

    // Directed: empty table with all flags set, day seven on check and new day.
    queue_cmd(ACT_CHECK, 31, 63, 0, 0);
    queue_cmd(ACT_CHECK, 31, 63, ALL_DAYS, 0);
    queue_cmd(ACT_NEW_DAY, 0, 0, ALL_DAYS, 0);
    // Zero-time add clears the shared flag; another day then fires its empty slot.
    queue_cmd(ACT_ADD, 0, 0, 0, 16'hFFFF);
    queue_cmd(ACT_CHECK, 0, 0, 3, 0);
    queue_cmd(ACT_ADD, 31, 63, ALL_DAYS, 16'h8000);
    queue_cmd(ACT_ADD, 0, 1, 2, 16'h0001);
    queue_cmd(ACT_NEW_DAY, 0, 0, 2, 0);
    queue_cmd(ACT_CHECK, 0, 0, 2, 0);
    queue_cmd(ACT_CHECK, 0, 1, 2, 0);
    queue_cmd(ACT_CHECK, 31, 63, 2, 0);
    // All-day adds fill day 2 and leave one slot free in every other row.
    for (int k = 0; k < SLOTS - 1; k++) begin
      queue_cmd(ACT_ADD, 2 * k, 4 * k, ALL_DAYS, k * 16'h1111);
    end
    queue_cmd(ACT_NEW_DAY, 0, 0, 4, 0);
    queue_cmd(ACT_CHECK, 31, 63, 4, 0);
    queue_cmd(ACT_ERASE, 31, 63, ALL_DAYS, 16'hFFFF);

    // Random: mostly add / new day / rising-time check episodes, some noise.
    drain_next = 1'b1;
    while (pending_cmds_q.size() < ITEMS_TARGET) begin
      gap_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) drain_next = 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_cmd(ACT_ERASE, $urandom_range(0, 31), $urandom_range(0, 63),
                    $urandom_range(0, 7), $urandom_range(0, 65535));
        end
        repeat ($urandom_range(1, 18)) begin
          hour   = $urandom_range(0, 31);
          minute = $urandom_range(0, 63);
          if ($urandom_range(0, 15) == 0) begin
            hour   = 0;
            minute = 0;
          end
          day = ($urandom_range(0, 4) == 0) ? ALL_DAYS : $urandom_range(0, LAST_DAY);
          queue_cmd(ACT_ADD, hour, minute, day, $urandom_range(0, 65535));
        end
        today = $urandom_range(0, LAST_DAY);
        queue_cmd(ACT_NEW_DAY, $urandom_range(0, 31), $urandom_range(0, 63), today,
                  $urandom_range(0, 65535));
        // Walk the clock forward through the day; now and then look at another day.
        tnow = $urandom_range(0, 120);
        repeat ($urandom_range(3, 16)) begin
          tnow += $urandom_range(0, 200);
          if (tnow > LAST_MINUTE) tnow = LAST_MINUTE;
          hour = tnow / MIN_PER_HOUR;
          if (hour > 31) hour = 31;
          minute = tnow - hour * MIN_PER_HOUR;
          day = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : today;
          queue_cmd(ACT_CHECK, hour, minute, day, $urandom_range(0, 65535));
        end
      end else begin
        repeat ($urandom_range(4, 12)) begin
          queue_cmd(wdst_action_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                    $urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 65535));
        end
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Poll on the falling edge so every clocked update of this cycle is settled.
    do @(negedge clk);
    while (pending_cmds_q.size() != 0 || holding_cmd || start || results_owed != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (err_cnt == 0) begin
      $display("tb_weekly_dispense_schedule_table: done, clean");
    end else begin
      $display("tb_weekly_dispense_schedule_table: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb_weekly_dispense_schedule_table: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/wdst_pkg.sv
rtl/wdst_slot_store.sv
rtl/weekly_dispense_schedule_table.sv
rtl/wdst_checker.sv
tb/tb_weekly_dispense_schedule_table.sv
